// ===== design/l2dt_pkg.sv =====
// ----------------------------------------------------------------------------
// l2dt_pkg
// shared types and constants for the l2 distance top-k selector
// ----------------------------------------------------------------------------
package l2dt_pkg;
  localparam int HEAP_DEPTH = 16;
  localparam int ELEM_BITS  = 16;
  localparam int DIST_W     = 44;
  localparam int IDX_W      = 31;
  localparam int HPOS_W     = $clog2(HEAP_DEPTH);
  localparam int FILL_W     = $clog2(HEAP_DEPTH + 1);
  localparam int KEEP_W     = 5;
  localparam int SQ_W       = 2 * (ELEM_BITS + 1);

  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_DRAIN = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] REG_KEEP = 2'd0;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // command handed from the front part to the heap engine
  typedef enum logic [1:0] {
    CMD_OFFER = 2'd0,
    CMD_DRAIN = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [DIST_W-1:0]  distance;
    logic [IDX_W-1:0]   idx;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } entry_t;
endpackage

// ===== design/l2dt_ram.sv =====
// ----------------------------------------------------------------------------
// l2dt_ram
// generic single-port-write, single-port-read RAM with registered read
// ----------------------------------------------------------------------------
module l2dt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/l2dt_front.sv =====
// ----------------------------------------------------------------------------
// l2dt_front
// accumulates squared element differences and issues heap commands
// ----------------------------------------------------------------------------
module l2dt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [15:0]          query_elem,
  input  logic [15:0]          base_elem,
  input  logic                 last_elem,
  input  logic [30:0]          vector_index,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output l2dt_pkg::cmd_t       cmd
);
  import l2dt_pkg::*;

  // stage 1: square of the difference, registered
  logic                    s1_v_r, s1_v_nxt;
  logic [1:0]              s1_op_r;
  logic                    s1_last_r;
  logic [IDX_W-1:0]        s1_idx_r;
  logic [SQ_W-1:0]         s1_sq_r;
  logic [DIST_W-1:0]       sum_r, sum_nxt;
  logic                    out_v_r, out_v_nxt;
  cmd_t                    out_r, out_nxt;

  logic signed [ELEM_BITS:0] diff;
  logic [ELEM_BITS:0]        mag;
  logic [DIST_W:0]           add;
  logic [DIST_W-1:0]         sat;
  logic                      s1_adv, s1_emits;

  assign diff = $signed({query_elem[ELEM_BITS-1], query_elem[ELEM_BITS-1:0]})
              - $signed({base_elem[ELEM_BITS-1], base_elem[ELEM_BITS-1:0]});
  assign mag  = diff[ELEM_BITS] ? (ELEM_BITS+1)'(-diff) : diff;

  assign add = {1'b0, sum_r} + (DIST_W+1)'(s1_sq_r);
  assign sat = add[DIST_W] ? DIST_MAX : add[DIST_W-1:0];

  assign s1_emits = (s1_op_r == OP_ACC && s1_last_r) || s1_op_r == OP_DRAIN
                 || s1_op_r == OP_CLEAR;
  // stage 1 moves when it needs no output slot or the slot frees
  assign s1_adv   = !s1_v_r || !s1_emits || !out_v_r || cmd_ready;
  assign in_ready = s1_adv;

  always_comb begin
    sum_nxt   = sum_r;
    out_v_nxt = out_v_r && !cmd_ready;
    out_nxt   = out_r;
    if (s1_v_r && s1_adv) begin
      unique case (s1_op_r)
        OP_ACC: begin
          sum_nxt = s1_last_r ? '0 : sat;
          if (s1_last_r) begin
            out_v_nxt        = 1'b1;
            out_nxt.kind     = CMD_OFFER;
            out_nxt.distance = sat;
            out_nxt.idx      = s1_idx_r;
          end
        end
        OP_DRAIN: begin
          out_v_nxt    = 1'b1;
          out_nxt.kind = CMD_DRAIN;
        end
        OP_CLEAR: begin
          out_v_nxt    = 1'b1;
          out_nxt.kind = CMD_CLEAR;
        end
        default: ;
      endcase
    end
    s1_v_nxt = s1_adv ? in_valid : s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      sum_r   <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      sum_r   <= sum_nxt;
    end
    out_r <= out_nxt;
    if (s1_adv) begin
      s1_op_r   <= opcode;
      s1_last_r <= last_elem;
      s1_idx_r  <= vector_index;
      s1_sq_r   <= mag * mag;
    end
  end

  assign cmd_valid = out_v_r;
  assign cmd       = out_r;
endmodule

// ===== design/l2dt_queue.sv =====
// ----------------------------------------------------------------------------
// l2dt_queue
// short command fifo between the front part and the heap engine
// ----------------------------------------------------------------------------
module l2dt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  l2dt_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output l2dt_pkg::cmd_t rd_data
);
  import l2dt_pkg::*;

  localparam int QD = 4;
  cmd_t       q_r [QD];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 3'(QD);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = q_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
    if (push) q_r[wp_r] <= wr_data;
  end
endmodule

// ===== design/l2dt_heap.sv =====
// ----------------------------------------------------------------------------
// l2dt_heap
// bounded max-heap engine: insert with sift-up, replace-root with sift-down,
// drain in array order, clear
// ----------------------------------------------------------------------------
module l2dt_heap (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [4:0]           keep_count,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  l2dt_pkg::cmd_t       cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [43:0]          res_dist,
  output logic [30:0]          res_idx,
  output logic                 res_entry_valid,
  output logic                 res_last,
  output logic                 busy
);
  import l2dt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPRD  = 4'd1;
  localparam logic [3:0] S_UPCMP = 4'd2;
  localparam logic [3:0] S_DNRDL = 4'd3;
  localparam logic [3:0] S_DNRDR = 4'd4;
  localparam logic [3:0] S_DNCMP = 4'd5;
  localparam logic [3:0] S_DRRD  = 4'd6;
  localparam logic [3:0] S_DRWT  = 4'd7;
  localparam logic [3:0] S_DROUT = 4'd8;

  logic [3:0]        st_r, st_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [HPOS_W:0]   pos_r, pos_nxt;   // one extra bit for child positions
  logic [HPOS_W:0]   oth_r, oth_nxt;   // parent, larger child or drain position
  entry_t            cur_r, cur_nxt;   // entry being moved
  entry_t            big_r, big_nxt;
  logic              bigv_r, bigv_nxt;

  logic              we;
  logic [HPOS_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;

  logic              ov_r, ov_nxt;
  entry_t            o_r, o_nxt;
  logic              oev_r, oev_nxt, ol_r, ol_nxt;

  logic [FILL_W-1:0] cap;
  logic [HPOS_W+1:0] lc, rc;

  l2dt_ram #(.WIDTH(DIST_W + IDX_W), .DEPTH(HEAP_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    if (keep_count == '0) cap = FILL_W'(1);
    else if (32'(keep_count) > HEAP_DEPTH) cap = FILL_W'(HEAP_DEPTH);
    else cap = FILL_W'(keep_count);
  end

  assign lc = {pos_r, 1'b1};
  assign rc = {pos_r, 1'b0} + (HPOS_W+2)'(2);

  assign cmd_ready = (st_r == S_IDLE) && !ov_r;

  always_comb begin
    st_nxt   = st_r;
    fill_nxt = fill_r;
    pos_nxt  = pos_r;
    oth_nxt  = oth_r;
    cur_nxt  = cur_r;
    big_nxt  = big_r;
    bigv_nxt = bigv_r;
    we       = 1'b0;
    waddr    = pos_r[HPOS_W-1:0];
    wdata    = cur_r;
    raddr    = oth_r[HPOS_W-1:0];
    ov_nxt   = ov_r && !res_ready;
    o_nxt    = o_r;
    oev_nxt  = oev_r;
    ol_nxt   = ol_r;
    unique case (st_r)
      S_IDLE: begin
        raddr = '0;
        if (cmd_valid && cmd_ready) begin
          unique case (cmd.kind)
            CMD_OFFER: begin
              cur_nxt.distance = cmd.distance;
              cur_nxt.idx      = cmd.idx;
              if (fill_r < cap) begin
                pos_nxt  = (HPOS_W+1)'(fill_r);
                fill_nxt = fill_r + 1'b1;
                oth_nxt  = ((HPOS_W+1)'(fill_r) - 1'b1) >> 1;
                st_nxt   = S_UPRD;
              end else if (fill_r != '0) begin
                pos_nxt = '0;
                st_nxt  = S_DNRDL;  // root read issued now, same address
              end
            end
            CMD_DRAIN: begin
              if (fill_r == '0) begin
                ov_nxt  = 1'b1;
                o_nxt   = '0;
                oev_nxt = 1'b0;
                ol_nxt  = 1'b1;
              end else begin
                oth_nxt = '0;
                st_nxt  = S_DRRD;
              end
            end
            CMD_CLEAR: fill_nxt = '0;
            default: ;
          endcase
        end
      end
      S_UPRD: begin
        // at the root place the new entry, else read its parent
        if (pos_r == '0) begin
          we     = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (rdata.distance >= cur_r.distance) begin
          we     = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          // parent moves down, entry moves up
          we      = 1'b1;
          wdata   = rdata;
          pos_nxt = oth_r;
          oth_nxt = (oth_r - 1'b1) >> 1;
          st_nxt  = S_UPRD;
        end
      end
      S_DNRDL: begin
        // issue read of left child; root/current value is cur_r
        bigv_nxt = 1'b0;
        if (pos_r == '0 && !(cur_r.distance < rdata.distance)) begin
          // root data arrives on the first pass: not smaller, heap untouched
          st_nxt = S_IDLE;
        end else if ((HPOS_W+2)'(fill_r) > lc) begin
          raddr  = lc[HPOS_W-1:0];
          st_nxt = S_DNRDR;
        end else begin
          we     = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_DNRDR: begin
        // left child data arrives; issue right child read
        big_nxt = rdata;
        if (rdata.distance > cur_r.distance) begin
          bigv_nxt = 1'b1;
          oth_nxt  = lc[HPOS_W:0];
        end
        raddr = rc[HPOS_W-1:0];
        st_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if ((HPOS_W+2)'(fill_r) > rc &&
            rdata.distance > (bigv_r ? big_r.distance : cur_r.distance)) begin
          bigv_nxt = 1'b1;
          big_nxt  = rdata;
          oth_nxt  = rc[HPOS_W:0];
        end
        st_nxt = S_DNRDL;
        if (((HPOS_W+2)'(fill_r) > rc &&
             rdata.distance > (bigv_r ? big_r.distance : cur_r.distance))) begin
          we      = 1'b1;
          wdata   = rdata;
          pos_nxt = rc[HPOS_W:0];
        end else if (bigv_r) begin
          we      = 1'b1;
          wdata   = big_r;
          pos_nxt = oth_r;
        end else begin
          we     = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_DRRD: begin
        st_nxt = S_DRWT;
      end
      S_DRWT: begin
        if (!ov_r || res_ready) begin
          ov_nxt  = 1'b1;
          o_nxt   = rdata;
          oev_nxt = 1'b1;
          ol_nxt  = (oth_r + 1'b1) == (HPOS_W+1)'(fill_r);
          if (ol_nxt) begin
            st_nxt = S_IDLE;
          end else begin
            oth_nxt = oth_r + 1'b1;
            st_nxt  = S_DROUT;
          end
        end
      end
      S_DROUT: begin
        st_nxt = S_DRWT;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      fill_r <= '0;
      ov_r   <= 1'b0;
      bigv_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      ov_r   <= ov_nxt;
      bigv_r <= bigv_nxt;
    end
    pos_r <= pos_nxt;
    oth_r <= oth_nxt;
    cur_r <= cur_nxt;
    big_r <= big_nxt;
    o_r   <= o_nxt;
    oev_r <= oev_nxt;
    ol_r  <= ol_nxt;
  end

  assign res_valid       = ov_r;
  assign res_dist        = o_r.distance;
  assign res_idx         = o_r.idx;
  assign res_entry_valid = oev_r;
  assign res_last        = ol_r;
  assign busy            = st_r != S_IDLE;
endmodule

// ===== design/l2_distance_topk_select.sv =====
// ----------------------------------------------------------------------------
// l2_distance_topk_select
// squared euclidean distance with a bounded max-heap of the smallest results
// ----------------------------------------------------------------------------
// throughput: one element per cycle while in_tready is high; a vector end
//   sends the heap engine through a sift-up (read parent, compare) or a
//   sift-down (read left, read right, compare) per level, hidden by a 4-entry
//   command queue when vectors are long; drain results follow one at a time
// reset: rst_n synchronous; clears sum, heap fill and queue, keep_count = 16
module l2_distance_topk_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] opcode, [17:2] query_elem, [33:18] base_elem, [64:34] vector_index
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,      // last_elem
  output logic        out_tvalid,
  input  logic        out_tready,
  // [43:0] distance, [74:44] result_index
  output logic [79:0] out_tdata,
  output logic        out_tuser,     // entry_valid
  output logic        out_tlast,     // last_result
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import l2dt_pkg::*;

  logic [KEEP_W-1:0] keep_r;
  logic              fq_v, fq_r, hq_v, hq_r, busy;
  cmd_t              fq_d, hq_d;
  logic [DIST_W-1:0] r_dist;
  logic [IDX_W-1:0]  r_idx;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_KEEP) ? 32'(keep_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_W'(16);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_KEEP) begin
      keep_r <= cfg_pwdata[KEEP_W-1:0];
    end
  end

  l2dt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .opcode(in_tdata[1:0]), .query_elem(in_tdata[17:2]),
    .base_elem(in_tdata[33:18]), .last_elem(in_tlast),
    .vector_index(in_tdata[64:34]),
    .cmd_valid(fq_v), .cmd_ready(fq_r), .cmd(fq_d)
  );

  l2dt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fq_v), .wr_ready(fq_r), .wr_data(fq_d),
    .rd_valid(hq_v), .rd_ready(hq_r), .rd_data(hq_d)
  );

  l2dt_heap u_heap (
    .clk(clk), .rst_n(rst_n), .keep_count(keep_r),
    .cmd_valid(hq_v), .cmd_ready(hq_r), .cmd(hq_d),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_dist(r_dist), .res_idx(r_idx),
    .res_entry_valid(out_tuser), .res_last(out_tlast), .busy(busy)
  );

  assign out_tdata = {5'd0, r_idx, r_dist};

  // an empty-heap result is always the last of its drain
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast) else $error("empty result not last");

  // heap engine takes no command while it is working
  a_busy_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !hq_r) else $error("command taken while busy");

  // held result stays stable under back-pressure
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
endmodule
